// ----- rtl/core/skl_pkg.sv -----
// Package for the sorted key list core: opcode codes and the per-cell mode struct.
// Used by skl_cell and sorted_key_list_core; depends on nothing.
package skl_pkg;

  localparam int KEY_W = 16;
  localparam int PAY_W = 16;
  localparam int POS_W = 6;
  localparam int OP_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_INS_END    = 4'd0,
    OP_INS_FRONT  = 4'd1,
    OP_INS_SORTED = 4'd2,
    OP_DEL_FRONT  = 4'd3,
    OP_DEL_END    = 4'd4,
    OP_DEL_AT     = 4'd5,
    OP_CLEAR      = 4'd6,
    OP_UPDATE     = 4'd7,
    OP_READ       = 4'd8
  } op_t;

  // Broadcast to every cell; at most one bit is set, and only for an operation that succeeds.
  typedef struct packed {
    logic ins_end;
    logic ins_front;
    logic ins_sorted;
    logic del_front;
    logic del_at;
    logic upd;
  } cell_mode_t;

endpackage

// ----- rtl/core/sorted_key_list_core.sv -----
// Top level of the sorted key list: control, entry count and the row of skl_cell instances.
// Depends on skl_pkg and skl_cell.
//
//  channel   ports                                         handshake
//  input     in_opcode in_key in_payload in_position       start, taken when busy is low
//  result    out_ok out_count out_key_out out_payload_out  out_valid strobe, one cycle
//            out_empty_res out_full_res
//
// Every operation is done by the whole row of cells shifting in parallel in the
// cycle the beat is taken, so busy stays low and a new beat may follow every cycle.
// The result appears in the cycle after the beat is taken, for exactly one cycle.
// The sorted insert point ripples through the split chain of the cells in that cycle.
// Reset (synchronous, active low) empties the list; entry storage keeps no reset.
// The receiver cannot stall, so results are simply strobed out.
module sorted_key_list_core import skl_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [OP_W-1:0]              in_opcode,
  input  logic [KEY_W-1:0]             in_key,
  input  logic [PAY_W-1:0]             in_payload,
  input  logic [POS_W-1:0]             in_position,
  output logic                         out_valid,
  output logic                         out_ok,
  output logic [$clog2(DEPTH+1)-1:0]   out_count,
  output logic [KEY_W-1:0]             out_key_out,
  output logic [PAY_W-1:0]             out_payload_out,
  output logic                         out_empty_res,
  output logic                         out_full_res
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  // Compare width wide enough for both the position field and the count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             valid_r;
  logic             ok_r, ok_nxt;
  logic [KEY_W-1:0] rkey_r, rkey_nxt;
  logic [PAY_W-1:0] rpay_r, rpay_nxt;

  logic             take, full, nonempty, pos_ok;
  logic [CMP_W-1:0] count_ext, pos_ext;
  cell_mode_t       mode;

  logic [KEY_W-1:0] cell_key   [DEPTH];
  logic [PAY_W-1:0] cell_pay   [DEPTH];
  logic             cell_hit   [DEPTH];
  logic             split      [DEPTH+1];

  // The row shifts in the same cycle, so a beat is never held off.
  assign busy = 1'b0;
  assign take = start && !busy;

  assign count_ext = CMP_W'(count_r);
  assign pos_ext   = CMP_W'(in_position);
  assign full      = (count_r == FULL_CNT);
  assign nonempty  = (count_r != '0);
  assign pos_ok    = (pos_ext < count_ext);

  // Decide success and the broadcast mode; a refused operation leaves every cell alone.
  always_comb begin
    mode      = '0;
    ok_nxt    = 1'b0;
    count_nxt = count_r;
    if (take) begin
      case (op_t'(in_opcode))
        OP_INS_END: begin
          ok_nxt       = !full;
          mode.ins_end = !full;
          if (!full) count_nxt = count_r + ONE_CNT;
        end
        OP_INS_FRONT: begin
          ok_nxt         = !full;
          mode.ins_front = !full;
          if (!full) count_nxt = count_r + ONE_CNT;
        end
        OP_INS_SORTED: begin
          ok_nxt          = !full;
          mode.ins_sorted = !full;
          if (!full) count_nxt = count_r + ONE_CNT;
        end
        OP_DEL_FRONT: begin
          ok_nxt         = nonempty;
          mode.del_front = nonempty;
          if (nonempty) count_nxt = count_r - ONE_CNT;
        end
        OP_DEL_END: begin
          ok_nxt = nonempty;
          if (nonempty) count_nxt = count_r - ONE_CNT;
        end
        OP_DEL_AT: begin
          ok_nxt      = pos_ok;
          mode.del_at = pos_ok;
          if (pos_ok) count_nxt = count_r - ONE_CNT;
        end
        OP_CLEAR: begin
          ok_nxt    = nonempty;
          count_nxt = '0;
        end
        OP_UPDATE: begin
          ok_nxt   = pos_ok;
          mode.upd = pos_ok;
        end
        OP_READ: begin
          ok_nxt = pos_ok;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  // Read port: each cell flags a position match, and the matching entry is OR-ed
  // onto the result bus. Only a successful read puts data there.
  always_comb begin
    rkey_nxt = '0;
    rpay_nxt = '0;
    if (take && (op_t'(in_opcode) == OP_READ) && pos_ok) begin
      for (int i = 0; i < DEPTH; i++) begin
        rkey_nxt = rkey_nxt | (cell_key[i] & {KEY_W{cell_hit[i]}});
        rpay_nxt = rpay_nxt | (cell_pay[i] & {PAY_W{cell_hit[i]}});
      end
    end
  end

  assign split[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0] lk, rk;
    logic [PAY_W-1:0] lp, rp;
    if (g == 0) begin : g_first
      assign lk = '0;
      assign lp = '0;
    end else begin : g_mid_l
      assign lk = cell_key[g-1];
      assign lp = cell_pay[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign rk = '0;
      assign rp = '0;
    end else begin : g_mid_r
      assign rk = cell_key[g+1];
      assign rp = cell_pay[g+1];
    end

    skl_cell #(
      .IDX   (g),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk           (clk),
      .mode          (mode),
      .count         (count_ext),
      .pos           (pos_ext),
      .new_key       (in_key),
      .new_payload   (in_payload),
      .split_in      (split[g]),
      .split_out     (split[g+1]),
      .left_key      (lk),
      .left_payload  (lp),
      .right_key     (rk),
      .right_payload (rp),
      .key_q         (cell_key[g]),
      .payload_q     (cell_pay[g]),
      .pos_hit       (cell_hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= take;
    end
  end

  // Result fields need no reset; the strobe qualifies them.
  always_ff @(posedge clk) begin
    ok_r   <= ok_nxt;
    rkey_r <= rkey_nxt;
    rpay_r <= rpay_nxt;
  end

  assign out_valid       = valid_r;
  assign out_ok          = ok_r;
  assign out_count       = count_r;
  assign out_key_out     = rkey_r;
  assign out_payload_out = rpay_r;
  assign out_empty_res   = (count_r == '0);
  assign out_full_res    = (count_r == FULL_CNT);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above capacity");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !ok_nxt) |=> (count_r == $past(count_r)))
    else $error("refused operation changed the entry count");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_key_out == '0 && out_payload_out == '0))
    else $error("refused operation returned read data");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid)
    else $error("accepted beat gave no result strobe");
`endif

endmodule

// ----- rtl/core/skl_cell.sv -----
// One cell of the sorted key list chain: holds one entry and shifts it to a neighbor.
// Depends on skl_pkg for the mode struct and field widths.
module skl_cell import skl_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CMP_W = 7
) (
  input  logic             clk,
  input  cell_mode_t       mode,
  input  logic [CMP_W-1:0] count,
  input  logic [CMP_W-1:0] pos,
  input  logic [KEY_W-1:0] new_key,
  input  logic [PAY_W-1:0] new_payload,
  input  logic             split_in,
  output logic             split_out,
  input  logic [KEY_W-1:0] left_key,
  input  logic [PAY_W-1:0] left_payload,
  input  logic [KEY_W-1:0] right_key,
  input  logic [PAY_W-1:0] right_payload,
  output logic [KEY_W-1:0] key_q,
  output logic [PAY_W-1:0] payload_q,
  output logic             pos_hit
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PAY_W-1:0] payload_r, payload_nxt;
  logic             at_cnt, at_pos, gt, mark, ins, del;

  assign at_cnt  = (count == MY_IDX);
  assign at_pos  = (pos == MY_IDX);
  assign gt      = (new_key > key_r);
  assign pos_hit = at_pos;
  assign ins     = mode.ins_end | mode.ins_front | mode.ins_sorted;
  assign del     = mode.del_front | mode.del_at;

  // The insertion or deletion point is the first cell that raises its mark.
  assign mark = (mode.ins_end & at_cnt) |
                (mode.ins_front & (IDX == 0)) |
                (mode.ins_sorted & (gt | at_cnt)) |
                mode.del_front |
                (mode.del_at & at_pos);
  assign split_out = split_in | mark;

  always_comb begin
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (ins) begin
      if (split_in) begin
        key_nxt     = left_key;
        payload_nxt = left_payload;
      end else if (mark) begin
        key_nxt     = new_key;
        payload_nxt = new_payload;
      end
    end else if (del && split_out) begin
      key_nxt     = right_key;
      payload_nxt = right_payload;
    end else if (mode.upd && at_pos) begin
      key_nxt     = new_key;
      payload_nxt = new_payload;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

  assign key_q     = key_r;
  assign payload_q = payload_r;

endmodule

// ----- dv/tb_sorted_key_list_core.sv -----
// Self-checking testbench for sorted_key_list_core: directed corner beats, then long
// random command runs, all checked against a scoreboard that keeps its own list copy.
// Depends on skl_pkg and the sorted_key_list_core RTL only.
`timescale 1ns / 100ps

module tb_sorted_key_list_core;
  import skl_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int RANDOM_BEATS = 1250;

  // One result beat as seen on the out_ ports.
  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] key_val;
    logic [PAY_W-1:0] payload_val;
    logic             empty;
    logic             full;
  } list_result_t;

  // The scoreboard keeps its own copy of the entry list. Every accepted command beat
  // is applied to that copy and the result it should produce is queued; every result
  // beat from the block is then compared against the oldest queued result.
  class list_scoreboard;
    logic [KEY_W-1:0] key_mem[LIST_DEPTH];
    logic [PAY_W-1:0] payload_mem[LIST_DEPTH];
    int unsigned      entry_total;
    int unsigned      error_count;
    list_result_t     expected_results[$];

    function new();
      entry_total = 0;
      error_count = 0;
    endfunction

    // Opens a hole at the given slot by shifting the tail up one place.
    function bit insert_entry(int unsigned at, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
      if (entry_total >= LIST_DEPTH || at > entry_total)
        return 1'b0;
      for (int unsigned j = entry_total; j > at; j--) begin
        key_mem[j]     = key_mem[j-1];
        payload_mem[j] = payload_mem[j-1];
      end
      key_mem[at]     = k;
      payload_mem[at] = p;
      entry_total++;
      return 1'b1;
    endfunction

    // Closes the slot by shifting the tail down one place.
    function bit remove_entry(int unsigned at);
      if (at >= entry_total)
        return 1'b0;
      for (int unsigned j = at; j + 1 < entry_total; j++) begin
        key_mem[j]     = key_mem[j+1];
        payload_mem[j] = payload_mem[j+1];
      end
      entry_total--;
      return 1'b1;
    endfunction

    function void note_command(logic [OP_W-1:0] opcode, logic [KEY_W-1:0] k,
                               logic [PAY_W-1:0] p, logic [POS_W-1:0] pos);
      list_result_t r;
      int unsigned  slot;
      r = '0;
      case (opcode)
        OP_INS_END:   r.ok = insert_entry(entry_total, k, p);
        OP_INS_FRONT: r.ok = insert_entry(0, k, p);
        OP_INS_SORTED: begin
          // Goes ahead of the first strictly smaller key, so equal keys keep arrival order.
          slot = 0;
          while (slot < entry_total && !(k > key_mem[slot]))
            slot++;
          r.ok = insert_entry(slot, k, p);
        end
        OP_DEL_FRONT: r.ok = remove_entry(0);
        OP_DEL_END: begin
          if (entry_total > 0) begin
            entry_total--;
            r.ok = 1'b1;
          end
        end
        OP_DEL_AT: r.ok = remove_entry(pos);
        OP_CLEAR: begin
          if (entry_total > 0) begin
            entry_total = 0;
            r.ok = 1'b1;
          end
        end
        OP_UPDATE: begin
          if (pos < entry_total) begin
            key_mem[pos]     = k;
            payload_mem[pos] = p;
            r.ok = 1'b1;
          end
        end
        OP_READ: begin
          if (pos < entry_total) begin
            r.key_val     = key_mem[pos];
            r.payload_val = payload_mem[pos];
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(entry_total);
      r.empty = (entry_total == 0);
      r.full  = (entry_total >= LIST_DEPTH);
      expected_results.push_back(r);
    endfunction

    function void check_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_val, act_val);
        error_count++;
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t exp;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with no command outstanding", $time);
        error_count++;
        return;
      end
      exp = expected_results.pop_front();
      check_field("ok",          exp.ok,          got.ok);
      check_field("count",       exp.count,       got.count);
      check_field("key_out",     exp.key_val,     got.key_val);
      check_field("payload_out", exp.payload_val, got.payload_val);
      check_field("empty_res",   exp.empty,       got.empty);
      check_field("full_res",    exp.full,        got.full);
    endfunction

    // Anything still queued at the end never came out of the block.
    function void close_out();
      if (expected_results.size() != 0) begin
        $display("%0t: %0d expected result beats never arrived", $time,
                 expected_results.size());
        error_count += expected_results.size();
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [OP_W-1:0]  in_opcode;
  logic [KEY_W-1:0] in_key;
  logic [PAY_W-1:0] in_payload;
  logic [POS_W-1:0] in_position;
  logic             out_valid;
  logic             out_ok;
  logic [CNT_W-1:0] out_count;
  logic [KEY_W-1:0] out_key_out;
  logic [PAY_W-1:0] out_payload_out;
  logic             out_empty_res;
  logic             out_full_res;

  list_scoreboard sb = new();

  sorted_key_list_core #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_key         (in_key),
    .in_payload     (in_payload),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_count      (out_count),
    .out_key_out    (out_key_out),
    .out_payload_out(out_payload_out),
    .out_empty_res  (out_empty_res),
    .out_full_res   (out_full_res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or stops producing results.
  initial begin
    #2_000_000;
    $display("tb_sorted_key_list_core: done, errors");
    $finish;
  end

  // Everything is sampled at the rising edge, before the block's own updates land.
  // A result beat is checked before the command beat taken at the same edge is noted;
  // the result always belongs to an earlier command, so the order keeps the queue right.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result('{out_ok, out_count, out_key_out, out_payload_out,
                          out_empty_res, out_full_res});
      if (start && !busy)
        sb.note_command(in_opcode, in_key, in_payload, in_position);
    end
  end

  // Presents one command beat from a falling edge and holds it until the block takes
  // it. Returns at the falling edge after the beat was taken, so the next call or gap
  // drives from there and start is only assigned once per edge.
  task automatic send_command(input logic [OP_W-1:0] opcode, input logic [KEY_W-1:0] k,
                              input logic [PAY_W-1:0] p, input logic [POS_W-1:0] pos);
    start       <= 1'b1;
    in_opcode   <= opcode;
    in_key      <= k;
    in_payload  <= p;
    in_position <= pos;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Idle cycles on the command side; the other inputs carry noise the block must ignore.
  task automatic idle_cycles(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      start       <= 1'b0;
      in_opcode   <= OP_W'($urandom);
      in_key      <= KEY_W'($urandom);
      in_payload  <= PAY_W'($urandom);
      in_position <= POS_W'($urandom);
      @(negedge clk);
    end
  endtask

  // Holds off the sender until every outstanding result has come back, with a bound
  // so a stuck block still reaches the end and fails there.
  task automatic wait_for_results();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    @(negedge clk);
    while (sb.expected_results.size() != 0 && waited < 1000) begin
      @(negedge clk);
      waited++;
    end
  endtask

  // Keys cluster on a few values often enough that sorted inserts hit equal keys.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return KEY_W'($urandom_range(0, 7)) << 8;
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Builds and sends one random command. While the list is growing inserts dominate,
  // so it regularly fills up and refuses inserts; while shrinking fewer inserts are sent.
  // Positions mostly land on live entries, the rest anywhere in the 6-bit range.
  task automatic send_random_command(input bit growing);
    int unsigned      roll;
    int unsigned      ins_share;
    logic [OP_W-1:0]  opcode;
    logic [POS_W-1:0] pos;
    roll      = $urandom_range(0, 999);
    ins_share = growing ? 620 : 250;
    if (roll < ins_share) begin
      case ($urandom_range(0, 3))
        0:       opcode = OP_INS_END;
        1:       opcode = OP_INS_FRONT;
        default: opcode = OP_INS_SORTED;
      endcase
    end else if (roll < ins_share + 200) begin
      case ($urandom_range(0, 2))
        0:       opcode = OP_DEL_FRONT;
        1:       opcode = OP_DEL_END;
        default: opcode = OP_DEL_AT;
      endcase
    end else if (roll < ins_share + 205) begin
      opcode = OP_CLEAR;
    end else if (roll < ins_share + 230) begin
      opcode = OP_W'($urandom_range(9, 15));
    end else if (roll < ins_share + 330) begin
      opcode = OP_UPDATE;
    end else begin
      opcode = OP_READ;
    end
    if (sb.entry_total > 0 && $urandom_range(0, 99) < 85)
      pos = POS_W'($urandom_range(0, sb.entry_total - 1));
    else
      pos = POS_W'($urandom);
    send_command(opcode, pick_key(), PAY_W'($urandom), pos);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst_left;
    int unsigned phase_left;
    bit          growing;

    // All inputs known from time zero, with reset held low before the directed beats.
    rst_n       = 1'b0;
    start       = 1'b0;
    in_opcode   = OP_READ;
    in_key      = '0;
    in_payload  = '0;
    in_position = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats. An empty list first: every delete, clear, update and read is
    // refused, as are the unused opcodes.
    send_command(OP_READ,      16'h0000, 16'h0000, 6'd0);
    send_command(OP_DEL_FRONT, 16'h0000, 16'h0000, 6'd0);
    send_command(OP_DEL_END,   16'h0000, 16'h0000, 6'd0);
    send_command(OP_DEL_AT,    16'h0000, 16'h0000, 6'd0);
    send_command(OP_CLEAR,     16'h0000, 16'h0000, 6'd0);
    send_command(OP_UPDATE,    16'hFFFF, 16'hFFFF, 6'd0);
    send_command(4'hF,         16'hFFFF, 16'hFFFF, 6'd63);
    send_command(4'h9,         16'h1234, 16'h5678, 6'd21);
    // Sorted inserts: largest key goes to the front, zero to the back, and an equal
    // key lands behind the one already there.
    send_command(OP_INS_SORTED, 16'h8000, 16'h0000, 6'd0);
    send_command(OP_INS_SORTED, 16'hFFFF, 16'hFFFF, 6'd0);
    send_command(OP_INS_SORTED, 16'h0000, 16'h1234, 6'd0);
    send_command(OP_INS_SORTED, 16'h8000, 16'hAAAA, 6'd0);
    send_command(OP_INS_FRONT,  16'h0100, 16'h5555, 6'd0);
    send_command(OP_INS_END,    16'h00FF, 16'h00FF, 6'd0);
    send_command(OP_READ,       16'h0000, 16'h0000, 6'd3);
    send_command(OP_READ,       16'h0000, 16'h0000, 6'd63);
    send_command(OP_UPDATE,     16'h7FFF, 16'h8000, 6'd2);
    send_command(OP_UPDATE,     16'h7FFF, 16'h8000, 6'd63);
    send_command(OP_READ,       16'h0000, 16'h0000, 6'd2);
    send_command(OP_DEL_AT,     16'h0000, 16'h0000, 6'd1);
    send_command(OP_DEL_AT,     16'h0000, 16'h0000, 6'd63);
    send_command(OP_DEL_FRONT,  16'h0000, 16'h0000, 6'd0);
    send_command(OP_DEL_END,    16'h0000, 16'h0000, 6'd0);
    send_command(OP_CLEAR,      16'h0000, 16'h0000, 6'd0);
    send_command(OP_READ,       16'h0000, 16'h0000, 6'd0);

    // Let the directed beats drain completely before the random run starts.
    wait_for_results();

    // Random run: bursts of back-to-back beats separated by random gaps, with the
    // list alternating between growing and shrinking phases of random length.
    sent       = 0;
    burst_left = 0;
    phase_left = 0;
    growing    = 1'b1;
    while (sent < RANDOM_BEATS) begin
      if (phase_left == 0) begin
        growing    = ~growing | (sent == 0);
        phase_left = $urandom_range(60, 200);
      end
      if (burst_left == 0) begin
        // About one gap in three is skipped so long unbroken stretches also occur.
        if ($urandom_range(0, 2) != 0)
          idle_cycles($urandom_range(1, 6));
        burst_left = $urandom_range(1, 40);
      end
      send_random_command(growing);
      sent++;
      burst_left--;
      phase_left--;
      // Now and then the sender stops until the block has answered everything.
      if (sent % 300 == 0)
        wait_for_results();
    end

    // Drain, then keep sampling in case a stray result beat shows up late.
    wait_for_results();
    repeat (4) @(negedge clk);
    sb.close_out();
    if (sb.error_count == 0)
      $display("tb_sorted_key_list_core: done, clean");
    else
      $display("tb_sorted_key_list_core: done, errors");
    $finish;
  end

endmodule
